/* sv/npz_pkg.sv */
// ----------------------------------------------------------------------------
// npz_pkg
// Shared types and constants of the neutrino pz solver: datapath widths,
// saturation limits and the side information that rides along the pipeline.
// ----------------------------------------------------------------------------
package npz_pkg;

	// w mass register
	localparam int unsigned W_BITS   = 24;
	// discriminant and its root
	localparam int unsigned D_W      = 114;
	localparam int unsigned S_W      = D_W / 2;
	// numerator, its magnitude and the denominator
	localparam int unsigned N_W      = 100;
	localparam int unsigned R_W      = N_W - 1;
	localparam int unsigned DEN_W    = 65;
	// quotient bits produced by the divider
	localparam int unsigned Q_W      = 32;

	localparam logic [31:0] PZ_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] PZ_MIN   = 32'h8000_0000;
	localparam logic [30:0] EN_MAX   = 31'h7FFF_FFFF;

	// event context through the product stages
	typedef struct packed {
		logic               zero;
		logic [30:0]        te;
		logic signed [31:0] ze;
		logic signed [31:0] xn;
		logic signed [31:0] yn;
		logic [63:0]        pt2;
		logic [63:0]        nsq;
		logic               dneg;
		logic               mneg;
	} mid_t;

	// context that rides through the discriminant root
	typedef struct packed {
		logic                  v;
		logic                  kill;
		logic signed [N_W-1:0] a;
		logic [30:0]           te;
		logic [63:0]           pt2;
		logic [63:0]           nsq;
		logic signed [31:0]    xn;
		logic signed [31:0]    yn;
	} root_t;

	// context that rides through the dividers
	typedef struct packed {
		logic               kill;
		logic [63:0]        nsq;
		logic signed [31:0] xn;
		logic signed [31:0] yn;
	} quo_t;

	// context through the first energy root
	typedef struct packed {
		logic               v;
		logic               kill;
		logic signed [31:0] xn;
		logic signed [31:0] yn;
		logic signed [31:0] pz;
		logic               big;
	} en1_t;

	// context through the second energy root
	typedef struct packed {
		logic signed [31:0] pz;
		logic               big;
	} en2_t;

endpackage

/* sv/npz_if.sv */
// ----------------------------------------------------------------------------
// npz_if
// Valid/ready channels of the neutrino pz solver: candidate event in,
// solution out.
// ----------------------------------------------------------------------------
interface npz_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] lep_px;
	logic signed [31:0] lep_py;
	logic signed [31:0] lep_pz;
	logic [30:0]        lep_energy;
	logic signed [31:0] met_x;
	logic signed [31:0] met_y;

	modport source (output valid, lep_px, lep_py, lep_pz, lep_energy, met_x, met_y,
		input ready);
	modport sink (input valid, lep_px, lep_py, lep_pz, lep_energy, met_x, met_y,
		output ready);
endinterface

interface npz_out_if;
	logic               valid;
	logic               ready;
	logic               solved;
	logic signed [31:0] nu_px;
	logic signed [31:0] nu_py;
	logic signed [31:0] nu1_pz;
	logic [30:0]        nu1_energy;
	logic signed [31:0] nu2_pz;
	logic [30:0]        nu2_energy;

	modport source (output valid, solved, nu_px, nu_py, nu1_pz, nu1_energy, nu2_pz,
		nu2_energy, input ready);
	modport sink (input valid, solved, nu_px, nu_py, nu1_pz, nu1_energy, nu2_pz,
		nu2_energy, output ready);
endinterface

/* sv/npz_mul.sv */
// ----------------------------------------------------------------------------
// npz_mul
// Unsigned pipelined multiplier: 32x32 partial products in the first stage,
// shifted sum of the partial products in the second.
// ----------------------------------------------------------------------------
module npz_mul #(
	parameter int AW = 64,
	parameter int BW = 64
) (
	input  logic               clk,
	input  logic               en,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic [AW+BW-1:0]   p
);

	localparam int NA = (AW + 31) / 32;
	localparam int NB = (BW + 31) / 32;
	localparam int SW = (NA + NB) * 32;

	logic [NA*32-1:0] a_x;
	logic [NB*32-1:0] b_x;
	logic [63:0]      pp_s1 [NA*NB];
	logic [SW-1:0]    acc;
	logic [AW+BW-1:0] p_s2;

	assign a_x = (NA*32)'(a);
	assign b_x = (NB*32)'(b);

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i*NB+j] <= 64'(a_x[i*32 +: 32]) * 64'(b_x[j*32 +: 32]);
				end
			end
		end
	end

	// weighted sum of the partial products
	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (SW'(pp_s1[i*NB+j]) << ((i + j) * 32));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[AW+BW-1:0];
		end
	end

	assign p = p_s2;

endmodule

/* sv/npz_sqrt.sv */
// ----------------------------------------------------------------------------
// npz_sqrt
// Pipelined floor square root, one root bit per stage, with a side tag that
// travels alongside the operand.
// ----------------------------------------------------------------------------
module npz_sqrt #(
	parameter int XW = 64,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [XW-1:0]   x,
	input  logic [PW-1:0]   tag_in,
	output logic [XW/2-1:0] root,
	output logic [PW-1:0]   tag_out
);

	localparam int RW    = XW / 2;
	localparam int REM_W = RW + 3;

	logic [REM_W-1:0] rem_s  [RW];
	logic [RW-1:0]    root_s [RW];
	logic [XW-1:0]    xs_s   [RW];
	logic [PW-1:0]    tag_s  [RW];

	genvar k;
	generate
		for (k = 0; k < RW; k++) begin : g_stage
			logic [REM_W-1:0] rem_i;
			logic [RW-1:0]    root_i;
			logic [XW-1:0]    xs_i;
			logic [PW-1:0]    tag_i;
			logic [REM_W-1:0] sh;
			logic [REM_W-1:0] trial;
			logic             ge;

			if (k == 0) begin : g_first
				assign rem_i  = '0;
				assign root_i = '0;
				assign xs_i   = x;
				assign tag_i  = tag_in;
			end else begin : g_next
				assign rem_i  = rem_s[k-1];
				assign root_i = root_s[k-1];
				assign xs_i   = xs_s[k-1];
				assign tag_i  = tag_s[k-1];
			end

			// bring down the next bit pair and try 4*root+1
			assign sh    = {rem_i[REM_W-3:0], xs_i[XW-1 -: 2]};
			assign trial = REM_W'({root_i, 2'b01});
			assign ge    = (sh >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= ge ? (sh - trial) : sh;
					root_s[k] <= {root_i[RW-2:0], ge};
					xs_s[k]   <= xs_i << 2;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					tag_s[k] <= '0;
				end else if (en) begin
					tag_s[k] <= tag_i;
				end
			end
		end
	endgenerate

	assign root    = root_s[RW-1];
	assign tag_out = tag_s[RW-1];

endmodule

/* sv/neutrino_pz_solver.sv */
// ----------------------------------------------------------------------------
// neutrino_pz_solver
// W-mass constrained longitudinal momentum of a massless neutrino.
// ----------------------------------------------------------------------------
// Takes one candidate event per cycle and returns the two pz roots with their
// energies; the whole path is one pipeline that advances whenever the output
// register is empty or being taken, so throughput is one item per cycle. The
// pipeline is made up of the 57-stage square root of the discriminant, the two
// 32-stage quotient dividers and the 32-stage energy roots, plus the product,
// sum and saturation stages around them. w_mass may only be written while no
// item is in flight.
module neutrino_pz_solver #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [npz_pkg::W_BITS-1:0]    cfg_wdata,
	npz_in_if.sink                        cand,
	npz_out_if.source                     sol
);

	localparam logic [63:0] W_RST_FULL = (64'd5269094 << FRAC_BITS) >> 16;
	localparam logic [npz_pkg::W_BITS-1:0] W_RST = W_RST_FULL[npz_pkg::W_BITS-1:0];
	localparam int QW = npz_pkg::Q_W;

	logic                        en;
	logic [npz_pkg::W_BITS-1:0]  w_mass_q;

	// pipeline advances when the output register can take a new item
	assign en         = !sol.valid || sol.ready;
	assign cand.ready = en;

	// w mass register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_mass_q <= W_RST;
		end else if (cfg_we) begin
			w_mass_q <= cfg_wdata;
		end
	end

	// ---------------- stage 1: input products ----------------
	logic               v_s1;
	npz_pkg::mid_t      c_s1;
	logic signed [63:0] pxn_s1, pyn_s1, pcx_s1, pcy_s1;
	logic signed [63:0] pta_s1, ptb_s1, nsa_s1, nsb_s1;
	logic [47:0]        w2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pxn_s1   <= cand.lep_px * cand.met_x;
			pyn_s1   <= cand.lep_py * cand.met_y;
			pcx_s1   <= cand.met_x * cand.lep_py;
			pcy_s1   <= cand.lep_px * cand.met_y;
			pta_s1   <= cand.lep_px * cand.lep_px;
			ptb_s1   <= cand.lep_py * cand.lep_py;
			nsa_s1   <= cand.met_x * cand.met_x;
			nsb_s1   <= cand.met_y * cand.met_y;
			w2_s1    <= 48'(w_mass_q) * 48'(w_mass_q);
			c_s1.zero <= (cand.lep_px == 32'sd0) && (cand.lep_py == 32'sd0);
			c_s1.te  <= cand.lep_energy;
			c_s1.ze  <= cand.lep_pz;
			c_s1.xn  <= cand.met_x;
			c_s1.yn  <= cand.met_y;
			c_s1.pt2 <= '0;
			c_s1.nsq <= '0;
			c_s1.dneg <= 1'b0;
			c_s1.mneg <= 1'b0;
		end
	end

	// ---------------- stage 2: dot, cross, pt and met sums ----------------
	logic               v_s2;
	npz_pkg::mid_t      c_s2, c2_c;
	logic signed [64:0] dot_s2, crs_s2;
	logic [47:0]        w2_s2;

	// context with the pt and met sums filled in
	always_comb begin
		c2_c     = c_s1;
		c2_c.pt2 = 64'(pta_s1) + 64'(ptb_s1);
		c2_c.nsq = 64'(nsa_s1) + 64'(nsb_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2   <= 65'(pxn_s1) + 65'(pyn_s1);
			crs_s2   <= 65'(pcx_s1) - 65'(pcy_s1);
			w2_s2    <= w2_s1;
			c_s2     <= c2_c;
		end
	end

	// ---------------- stage 3: magnitudes ----------------
	logic               v_s3;
	npz_pkg::mid_t      c_s3, c3_c;
	logic [63:0]        absdot_s3, abscrs_s3;
	logic [65:0]        absm_s3;
	logic [31:0]        zmag_s3;
	logic [47:0]        w2_s3;
	logic signed [64:0] ndot, ncrs;
	logic signed [66:0] m_c, nm_c;
	logic signed [31:0] nz_c;

	always_comb begin
		ndot = -dot_s2;
		ncrs = -crs_s2;
		m_c  = $signed({19'b0, w2_s2}) + (67'(dot_s2) <<< 1);
		nm_c = -m_c;
		nz_c = 32'sd0 - c_s2.ze;
		c3_c      = c_s2;
		c3_c.dneg = dot_s2[64];
		c3_c.mneg = m_c[66];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			absdot_s3 <= dot_s2[64] ? ndot[63:0] : dot_s2[63:0];
			abscrs_s3 <= crs_s2[64] ? ncrs[63:0] : crs_s2[63:0];
			absm_s3   <= m_c[66] ? nm_c[65:0] : m_c[65:0];
			zmag_s3   <= c_s2.ze[31] ? nz_c : c_s2.ze;
			w2_s3     <= w2_s2;
			c_s3      <= c3_c;
		end
	end

	// ---------------- stages 4-5: wide products ----------------
	logic          v_s4, v_s5;
	npz_pkg::mid_t c_s4, c_s5;
	logic [127:0]  c2_p;
	logic [111:0]  wd_p;
	logic [95:0]   w4_p;
	logic [97:0]   am_p;

	npz_mul #(.AW(64), .BW(64)) u_mul_c2 (
		.clk(clk), .en(en), .a(abscrs_s3), .b(abscrs_s3), .p(c2_p));
	npz_mul #(.AW(64), .BW(48)) u_mul_wd (
		.clk(clk), .en(en), .a(absdot_s3), .b(w2_s3), .p(wd_p));
	npz_mul #(.AW(48), .BW(48)) u_mul_w4 (
		.clk(clk), .en(en), .a(w2_s3), .b(w2_s3), .p(w4_p));
	npz_mul #(.AW(66), .BW(32)) u_mul_am (
		.clk(clk), .en(en), .a(absm_s3), .b(zmag_s3), .p(am_p));

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4 <= c_s3;
			c_s5 <= c_s4;
		end
	end

	// ---------------- stage 6: discriminant ----------------
	logic                            v_s6;
	npz_pkg::root_t                  rt_s6, rt_in;
	logic [npz_pkg::D_W-1:0]         d_s6;
	logic signed [129:0]             wd_x, d4_c;
	logic signed [npz_pkg::N_W-1:0]  am_x, a_c;

	always_comb begin
		wd_x = $signed({18'b0, wd_p});
		d4_c = (c_s5.dneg ? -wd_x : wd_x) + $signed({36'b0, w4_p[95:2]})
			- $signed({2'b0, c2_p});
		am_x = $signed({2'b0, am_p});
		a_c  = (c_s5.mneg ^ c_s5.ze[31]) ? -am_x : am_x;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6      <= d4_c[129] ? '0 : {d4_c[111:0], w4_p[1:0]};
			rt_s6.v   <= 1'b0;
			rt_s6.kill <= c_s5.zero || (d4_c[129] && (c_s5.te != 31'd0));
			rt_s6.a   <= a_c;
			rt_s6.te  <= c_s5.te;
			rt_s6.pt2 <= c_s5.pt2;
			rt_s6.nsq <= c_s5.nsq;
			rt_s6.xn  <= c_s5.xn;
			rt_s6.yn  <= c_s5.yn;
		end
	end

	always_comb begin
		rt_in   = rt_s6;
		rt_in.v = v_s6;
	end

	// ---------------- discriminant root ----------------
	logic [npz_pkg::S_W-1:0] s_root;
	npz_pkg::root_t          rt_o;

	npz_sqrt #(.XW(npz_pkg::D_W), .PW($bits(npz_pkg::root_t))) u_sqrt_d (
		.clk(clk), .arst_n(arst_n), .en(en), .x(d_s6), .tag_in(rt_in),
		.root(s_root), .tag_out(rt_o));

	// ---------------- energy times root ----------------
	npz_pkg::root_t rt_b1_q, rt_b2_q;
	logic [87:0]    b_p;

	npz_mul #(.AW(31), .BW(npz_pkg::S_W)) u_mul_b (
		.clk(clk), .en(en), .a(rt_o.te), .b(s_root), .p(b_p));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_b1_q <= '0;
			rt_b2_q <= '0;
		end else if (en) begin
			rt_b1_q <= rt_o;
			rt_b2_q <= rt_b1_q;
		end
	end

	// ---------------- numerators ----------------
	logic                            v_sp;
	npz_pkg::quo_t                   qc_sp;
	logic signed [npz_pkg::N_W-1:0]  n_sp [2];
	logic [npz_pkg::DEN_W-1:0]       den_sp;
	logic signed [npz_pkg::N_W-1:0]  b_x;

	assign b_x = $signed({12'b0, b_p});

	always_ff @(posedge clk) begin
		if (en) begin
			n_sp[0]    <= rt_b2_q.a + b_x;
			n_sp[1]    <= rt_b2_q.a - b_x;
			den_sp     <= {rt_b2_q.pt2, 1'b0};
			qc_sp.kill <= rt_b2_q.kill;
			qc_sp.nsq  <= rt_b2_q.nsq;
			qc_sp.xn   <= rt_b2_q.xn;
			qc_sp.yn   <= rt_b2_q.yn;
		end
	end

	// ---------------- numerator magnitudes ----------------
	logic                            v_sq;
	npz_pkg::quo_t                   qc_sq;
	logic [npz_pkg::R_W-1:0]         absn_sq [2];
	logic                            neg_sq  [2];
	logic [npz_pkg::DEN_W-1:0]       den_sq;
	logic signed [npz_pkg::N_W-1:0]  nn_c    [2];

	always_comb begin
		for (int ln = 0; ln < 2; ln++) begin
			nn_c[ln] = -n_sp[ln];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ln = 0; ln < 2; ln++) begin
				neg_sq[ln]  <= n_sp[ln][npz_pkg::N_W-1];
				absn_sq[ln] <= n_sp[ln][npz_pkg::N_W-1] ? nn_c[ln][npz_pkg::R_W-1:0]
					: n_sp[ln][npz_pkg::R_W-1:0];
			end
			den_sq <= den_sp;
			qc_sq  <= qc_sp;
		end
	end

	// ---------------- quotient overflow check ----------------
	logic                       v_sr;
	npz_pkg::quo_t              qc_sr;
	logic [npz_pkg::R_W-1:0]    rem_sr [2];
	logic                       neg_sr [2];
	logic                       ovf_sr [2];
	logic [npz_pkg::DEN_W-1:0]  den_sr;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ln = 0; ln < 2; ln++) begin
				rem_sr[ln] <= absn_sq[ln];
				neg_sr[ln] <= neg_sq[ln];
				ovf_sr[ln] <= absn_sq[ln] >= {2'b0, den_sq, 32'b0};
			end
			den_sr <= den_sq;
			qc_sr  <= qc_sq;
		end
	end

	// ---------------- restoring dividers, one quotient bit per stage ----------------
	logic                       dv_v_s   [QW];
	npz_pkg::quo_t              dv_c_s   [QW];
	logic [npz_pkg::DEN_W-1:0]  dv_den_s [QW];
	logic [npz_pkg::R_W-1:0]    dv_rem_s [2][QW];
	logic [QW-1:0]              dv_q_s   [2][QW];
	logic                       dv_neg_s [2][QW];
	logic                       dv_ovf_s [2][QW];

	genvar k, ln;
	generate
		for (k = 0; k < QW; k++) begin : g_div
			logic                      v_i;
			npz_pkg::quo_t             c_i;
			logic [npz_pkg::DEN_W-1:0] den_i;
			logic [npz_pkg::R_W-1:0]   dsh;

			if (k == 0) begin : g_first
				assign v_i   = v_sr;
				assign c_i   = qc_sr;
				assign den_i = den_sr;
			end else begin : g_next
				assign v_i   = dv_v_s[k-1];
				assign c_i   = dv_c_s[k-1];
				assign den_i = dv_den_s[k-1];
			end

			// divisor aligned to this quotient bit
			assign dsh = npz_pkg::R_W'(den_i) << (QW - 1 - k);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[k] <= 1'b0;
				end else if (en) begin
					dv_v_s[k] <= v_i;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_c_s[k]   <= c_i;
					dv_den_s[k] <= den_i;
				end
			end

			for (ln = 0; ln < 2; ln++) begin : g_lane
				logic [npz_pkg::R_W-1:0] rem_i;
				logic [QW-1:0]           q_i;
				logic                    neg_i, ovf_i, ge;

				if (k == 0) begin : g_first
					assign rem_i = rem_sr[ln];
					assign q_i   = '0;
					assign neg_i = neg_sr[ln];
					assign ovf_i = ovf_sr[ln];
				end else begin : g_next
					assign rem_i = dv_rem_s[ln][k-1];
					assign q_i   = dv_q_s[ln][k-1];
					assign neg_i = dv_neg_s[ln][k-1];
					assign ovf_i = dv_ovf_s[ln][k-1];
				end

				assign ge = rem_i >= dsh;

				always_ff @(posedge clk) begin
					if (en) begin
						dv_rem_s[ln][k] <= ge ? (rem_i - dsh) : rem_i;
						dv_q_s[ln][k]   <= {q_i[QW-2:0], ge};
						dv_neg_s[ln][k] <= neg_i;
						dv_ovf_s[ln][k] <= ovf_i;
					end
				end
			end
		end
	endgenerate

	// ---------------- pz saturation and q squared ----------------
	logic               v_sf;
	npz_pkg::quo_t      qc_sf;
	logic signed [31:0] pz_sf  [2];
	logic               big_sf [2];
	logic [63:0]        sq_sf  [2];
	logic [QW-1:0]      q_c    [2];
	logic               big_c  [2];
	logic signed [31:0] pz_c   [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			q_c[i]   = dv_q_s[i][QW-1];
			big_c[i] = dv_ovf_s[i][QW-1] || q_c[i][QW-1];
			if (dv_neg_s[i][QW-1]) begin
				pz_c[i] = (dv_ovf_s[i][QW-1] || (q_c[i] > npz_pkg::PZ_MIN))
					? npz_pkg::PZ_MIN : (32'd0 - q_c[i]);
			end else begin
				pz_c[i] = big_c[i] ? npz_pkg::PZ_MAX : q_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				pz_sf[i]  <= pz_c[i];
				big_sf[i] <= big_c[i];
				sq_sf[i]  <= 64'(q_c[i][QW-2:0]) * 64'(q_c[i][QW-2:0]);
			end
			qc_sf <= dv_c_s[QW-1];
		end
	end

	// ---------------- energy radicand ----------------
	logic               v_sg;
	npz_pkg::quo_t      qc_sg;
	logic signed [31:0] pz_sg  [2];
	logic               big_sg [2];
	logic [63:0]        es_sg  [2];
	npz_pkg::en1_t      e1_in;
	npz_pkg::en2_t      e2_in;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				es_sg[i]  <= sq_sf[i] + qc_sf.nsq;
				pz_sg[i]  <= pz_sf[i];
				big_sg[i] <= big_sf[i];
			end
			qc_sg <= qc_sf;
		end
	end

	always_comb begin
		e1_in.v    = v_sg;
		e1_in.kill = qc_sg.kill;
		e1_in.xn   = qc_sg.xn;
		e1_in.yn   = qc_sg.yn;
		e1_in.pz   = pz_sg[0];
		e1_in.big  = big_sg[0];
		e2_in.pz   = pz_sg[1];
		e2_in.big  = big_sg[1];
	end

	// ---------------- energy roots ----------------
	logic [31:0]   e1_root, e2_root;
	npz_pkg::en1_t e1_o;
	npz_pkg::en2_t e2_o;

	npz_sqrt #(.XW(64), .PW($bits(npz_pkg::en1_t))) u_sqrt_e1 (
		.clk(clk), .arst_n(arst_n), .en(en), .x(es_sg[0]), .tag_in(e1_in),
		.root(e1_root), .tag_out(e1_o));
	npz_sqrt #(.XW(64), .PW($bits(npz_pkg::en2_t))) u_sqrt_e2 (
		.clk(clk), .arst_n(arst_n), .en(en), .x(es_sg[1]), .tag_in(e2_in),
		.root(e2_root), .tag_out(e2_o));

	// ---------------- output register ----------------
	logic               out_v_q;
	logic               solved_q;
	logic signed [31:0] nu_px_q, nu_py_q, nu1_pz_q, nu2_pz_q;
	logic [30:0]        nu1_en_q, nu2_en_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (e1_o.kill) begin
				solved_q <= 1'b0;
				nu_px_q  <= '0;
				nu_py_q  <= '0;
				nu1_pz_q <= '0;
				nu1_en_q <= '0;
				nu2_pz_q <= '0;
				nu2_en_q <= '0;
			end else begin
				solved_q <= 1'b1;
				nu_px_q  <= e1_o.xn;
				nu_py_q  <= e1_o.yn;
				nu1_pz_q <= e1_o.pz;
				nu1_en_q <= (e1_o.big || e1_root[31]) ? npz_pkg::EN_MAX : e1_root[30:0];
				nu2_pz_q <= e2_o.pz;
				nu2_en_q <= (e2_o.big || e2_root[31]) ? npz_pkg::EN_MAX : e2_root[30:0];
			end
		end
	end

	// ---------------- stage valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_sp    <= 1'b0;
			v_sq    <= 1'b0;
			v_sr    <= 1'b0;
			v_sf    <= 1'b0;
			v_sg    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= cand.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_sp    <= rt_b2_q.v;
			v_sq    <= v_sp;
			v_sr    <= v_sq;
			v_sf    <= dv_v_s[QW-1];
			v_sg    <= v_sf;
			out_v_q <= e1_o.v;
		end
	end

	assign sol.valid      = out_v_q;
	assign sol.solved     = solved_q;
	assign sol.nu_px      = nu_px_q;
	assign sol.nu_py      = nu_py_q;
	assign sol.nu1_pz     = nu1_pz_q;
	assign sol.nu1_energy = nu1_en_q;
	assign sol.nu2_pz     = nu2_pz_q;
	assign sol.nu2_energy = nu2_en_q;

	// ---------------- assertions ----------------
	// an unsolved item carries all-zero neutrino fields
	a_unsolved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sol.valid && !sol.solved |-> sol.nu_px == 32'sd0 && sol.nu_py == 32'sd0 &&
			sol.nu1_pz == 32'sd0 && sol.nu1_energy == 31'd0 &&
			sol.nu2_pz == 32'sd0 && sol.nu2_energy == 31'd0)
		else $error("unsolved item with nonzero neutrino fields");

	// equal roots must give equal energies
	a_same_root: assert property (@(posedge clk) disable iff (!arst_n)
		sol.valid && sol.nu1_pz == sol.nu2_pz |-> sol.nu1_energy == sol.nu2_energy)
		else $error("equal pz roots with different energies");

endmodule
